// ----- hdl/fcwl_pkg.sv -----
// fcwl_pkg: constants, entry types and codes of the front-coded word list encoder
// used by the interfaces and every module of the block but fcwl_ram; depends on nothing

package fcwl_pkg;

    localparam int CHAR_W      = 7;
    localparam int BYTE_W      = 8;
    localparam int WORD_DEPTH  = 128;
    localparam int POS_W       = 7;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [POS_W-1:0]  CLIP_COUNT = 7'd127;
    localparam logic [CHAR_W-1:0] NEWLINE    = 7'd10;

    // what the back end has to send for one queued request
    typedef enum logic [1:0] {
        KIND_LIT      = 2'd0,
        KIND_CODE     = 2'd1,
        KIND_CODE_LIT = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [POS_W-1:0]  code;
        logic [CHAR_W-1:0] chr;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- hdl/fcwl_char_if.sv -----
// fcwl_char_if: input channel, one character request per handshake
// depends on fcwl_pkg

interface fcwl_char_if import fcwl_pkg::*; ;
    logic              valid;
    logic              ready;
    logic              list_start;
    logic [CHAR_W-1:0] char_in;

    modport source (output valid, output list_start, output char_in, input ready);
    modport sink   (input valid, input list_start, input char_in, output ready);
endinterface

// ----- hdl/fcwl_byte_if.sv -----
// fcwl_byte_if: output channel, one encoded byte per handshake
// depends on fcwl_pkg

interface fcwl_byte_if import fcwl_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_out;
    logic              last_of_run;

    modport source (output valid, output byte_out, output last_of_run, input ready);
    modport sink   (input valid, input byte_out, input last_of_run, output ready);
endinterface

// ----- hdl/fcwl_ram.sv -----
// fcwl_ram: generic single-write, single-read ram with registered read data
// standalone, no package needed

module fcwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/fcwl_queue.sv -----
// fcwl_queue: small register fifo of send requests between front and back end
// depends on fcwl_pkg for the entry and status types

module fcwl_queue import fcwl_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_entry,
    output t_q_status o_status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_slot [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    assign o_entry        = r_slot[r_rptr];
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

// ----- hdl/fcwl_front.sv -----
// fcwl_front: accepts characters, tracks the prefix match against the previous word
// and queues send requests; depends on fcwl_pkg, fcwl_char_if and fcwl_ram

module fcwl_front import fcwl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcwl_char_if.sink i_char,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_entry    o_entry
);

    logic [POS_W-1:0]  r_prev_len, n_prev_len;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_matching, n_matching;
    logic              r_first, n_first;

    logic              accept;
    logic              ls;
    logic [CHAR_W-1:0] c;
    logic              is_nl;
    logic [POS_W-1:0]  eff_pos;
    logic              eff_first;
    logic              eff_matching;
    logic              can_keep;
    logic              hit;
    logic              we;
    logic [CHAR_W-1:0] rdata;

    assign i_char.ready = !i_q_status.full;
    assign accept       = i_char.valid && i_char.ready;
    assign ls           = i_char.list_start;
    assign c            = i_char.char_in;
    assign is_nl        = (c == NEWLINE);

    // list start restarts first-word mode before this character
    assign eff_pos      = ls ? '0 : r_pos;
    assign eff_first    = ls | r_first;
    assign eff_matching = ls | r_matching;
    assign can_keep     = (eff_pos != CLIP_COUNT);
    assign hit          = (eff_pos < r_prev_len) && can_keep && (rdata == c);

    always_comb begin
        n_prev_len = r_prev_len;
        n_pos      = r_pos;
        n_matching = r_matching;
        n_first    = r_first;
        o_push     = 1'b0;
        o_entry    = '{kind: KIND_LIT, code: eff_pos, chr: c};
        we         = 1'b0;
        if (accept) begin
            n_prev_len = ls ? '0 : r_prev_len;
            n_pos      = eff_pos;
            n_matching = eff_matching;
            n_first    = eff_first;
            if (eff_first || !eff_matching) begin
                if (is_nl) begin
                    n_prev_len = eff_pos;
                    n_pos      = '0;
                    n_matching = 1'b1;
                    n_first    = 1'b0;
                end else begin
                    we     = can_keep;
                    n_pos  = can_keep ? eff_pos + 1'b1 : eff_pos;
                    o_push = 1'b1;
                end
            end else if (is_nl) begin
                o_push        = 1'b1;
                o_entry.kind  = KIND_CODE;
                n_prev_len    = eff_pos;
                n_pos         = '0;
                n_matching    = 1'b1;
                n_first       = 1'b0;
            end else if (hit) begin
                n_pos = eff_pos + 1'b1;
                if (eff_pos == CLIP_COUNT - 1'b1) begin
                    n_matching   = 1'b0;
                    o_push       = 1'b1;
                    o_entry.kind = KIND_CODE;
                    o_entry.code = CLIP_COUNT;
                end
            end else begin
                o_push       = 1'b1;
                o_entry.kind = KIND_CODE_LIT;
                n_matching   = 1'b0;
                we           = can_keep;
                n_pos        = can_keep ? eff_pos + 1'b1 : eff_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_len <= '0;
            r_pos      <= '0;
            r_matching <= 1'b1;
            r_first    <= 1'b1;
        end else begin
            r_prev_len <= n_prev_len;
            r_pos      <= n_pos;
            r_matching <= n_matching;
            r_first    <= n_first;
        end
    end

    // read address follows the next position, so rdata always holds word[r_pos]
    fcwl_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (WORD_DEPTH)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (eff_pos),
        .i_wdata (c),
        .i_raddr (n_pos),
        .o_rdata (rdata)
    );

endmodule

// ----- hdl/fcwl_back.sv -----
// fcwl_back: pops send requests and drives the byte output register
// depends on fcwl_pkg and fcwl_byte_if

module fcwl_back import fcwl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_entry      i_entry,
    input  t_q_status   i_q_status,
    output logic        o_pop,
    fcwl_byte_if.source o_byte
);

    typedef enum logic [1:0] {
        ST_NEXT   = 2'b01,
        ST_SECOND = 2'b10
    } t_back_state;

    t_back_state       r_state, n_state;
    logic              r_valid, n_valid;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic              r_last, n_last;
    logic [CHAR_W-1:0] r_pend, n_pend;
    logic              can_load;

    assign can_load = !r_valid || o_byte.ready;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_byte  = r_byte;
        n_last  = r_last;
        n_pend  = r_pend;
        o_pop   = 1'b0;
        if (can_load) begin
            case (r_state)
                ST_SECOND: begin
                    n_valid = 1'b1;
                    n_byte  = {1'b0, r_pend};
                    n_last  = 1'b1;
                    n_state = ST_NEXT;
                end
                ST_NEXT: begin
                    n_valid = !i_q_status.empty;
                    if (!i_q_status.empty) begin
                        o_pop = 1'b1;
                        case (i_entry.kind)
                            KIND_LIT: begin
                                n_byte = {1'b0, i_entry.chr};
                                n_last = 1'b1;
                            end
                            KIND_CODE: begin
                                n_byte = {1'b1, i_entry.code};
                                n_last = 1'b1;
                            end
                            KIND_CODE_LIT: begin
                                n_byte  = {1'b1, i_entry.code};
                                n_last  = 1'b0;
                                n_pend  = i_entry.chr;
                                n_state = ST_SECOND;
                            end
                            default: begin
                                n_byte = {1'b0, i_entry.chr};
                                n_last = 1'b1;
                            end
                        endcase
                    end
                end
                default: begin
                    n_valid = 1'b0;
                    n_state = ST_NEXT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NEXT;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_pend <= n_pend;
    end

    assign o_byte.valid       = r_valid;
    assign o_byte.byte_out    = r_byte;
    assign o_byte.last_of_run = r_last;

endmodule

// ----- hdl/front_coded_word_list_encoder.sv -----
// front_coded_word_list_encoder: top level of the front-coded word list encoder
// depends on fcwl_pkg, fcwl_char_if, fcwl_byte_if, fcwl_front, fcwl_queue, fcwl_back
//
// usage
//   i_char carries one character per request: char_in and list_start, which
//   marks the first character of a new list. a newline ends each word.
//   o_byte carries the encoded stream, one byte per request: below 128 a
//   literal character, 128 plus the shared prefix count otherwise;
//   last_of_run flags the last byte caused by one character.
//   a character causes zero, one or two bytes (prefix code then character
//   on a mismatch).
// throughput
//   one character per cycle is accepted while the queue is not full; each
//   request is registered in the queue, then its byte in the output register.
//   the output side moves one byte per cycle while o_byte.ready is high, so
//   the second byte of a mismatch is absorbed by the request queue
//   (QUEUE_DEPTH entries) between the front end and the back end.
// stalls and reset
//   when o_byte.ready is low the output register holds, the queue fills,
//   and i_char.ready drops once the queue is full; nothing is lost.
//   reset clears the match state and the queue and starts first-word mode;
//   the previous-word memory is not cleared, since an entry is only read
//   after it has been written within the current list.

module front_coded_word_list_encoder import fcwl_pkg::*; #(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcwl_char_if.sink   i_char,
    fcwl_byte_if.source o_byte
);

    // requests from the front end into the queue
    logic      q_push;
    t_entry    q_in;
    // requests from the queue into the back end
    logic      q_pop;
    t_entry    q_out;
    t_q_status q_status;

    // front end: prefix tracking and previous-word memory
    fcwl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_char     (i_char),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    // decoupling queue
    fcwl_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_in),
        .i_pop    (q_pop),
        .o_entry  (q_out),
        .o_status (q_status)
    );

    // back end: splits requests into bytes
    fcwl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_entry    (q_out),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_byte     (o_byte)
    );

    // no request pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_status.full)
        else $error("request pushed into full queue");

    // no request popped from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_status.empty)
        else $error("request popped from empty queue");

    // only a prefix code can be followed by another byte of the same character
    a_first_of_two_is_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte.valid && !o_byte.last_of_run) |-> o_byte.byte_out[BYTE_W-1])
        else $error("non-final byte is not a prefix code");

endmodule
